### hdl/bgd_pkg.sv
`default_nettype none
package bgd_pkg;

  localparam int TimeW  = 32;
  localparam int CfgW   = 16;
  localparam int LaneN  = 3;
  localparam int EventW = 4;
  localparam int PhaseW = 3;

  typedef logic [EventW-1:0] event_t;
  typedef logic [TimeW-1:0]  stamp_t;
  typedef logic [CfgW-1:0]   cfg_word_t;

  // configuration register indexes
  localparam logic CfgIdxLongPress = 1'b0;
  localparam logic CfgIdxDoubleGap = 1'b1;

  localparam cfg_word_t LongPressRst = 16'd2000;
  localparam cfg_word_t DoubleGapRst = 16'd350;

  localparam event_t EvNone         = 4'd0;
  localparam event_t EvModeToggle   = 4'd1;
  localparam event_t EvSleep        = 4'd2;
  localparam event_t EvPlayPause    = 4'd3;
  localparam event_t EvNext         = 4'd4;
  localparam event_t EvPickerOpen   = 4'd5;
  localparam event_t EvPickerSelect = 4'd6;
  localparam event_t EvVolumeUp     = 4'd7;
  localparam event_t EvSystemInfo   = 4'd8;

  // per-button personality
  typedef struct packed {
    event_t ev_short;
    event_t ev_long;
    event_t ev_double;
    logic   has_double;
  } lane_const_t;

  localparam lane_const_t LaneLeft  = '{EvModeToggle, EvSleep, EvPlayPause, 1'b1};
  localparam lane_const_t LaneMid   = '{EvNext, EvPickerOpen, EvPickerSelect, 1'b1};
  localparam lane_const_t LaneRight = '{EvVolumeUp, EvSystemInfo, EvNone, 1'b0};

endpackage
`default_nettype wire

### hdl/bgd_if.sv
`default_nettype none
interface bgd_in_if;
  logic                valid;
  logic                ready;
  logic                left_low;
  logic                mid_low;
  logic                right_low;
  bgd_pkg::stamp_t     now_ms;

  modport source (output valid, left_low, mid_low, right_low, now_ms, input ready);
  modport sink   (input valid, left_low, mid_low, right_low, now_ms, output ready);
endinterface

interface bgd_out_if;
  logic                valid;
  logic                ready;
  bgd_pkg::event_t     gesture_event;

  modport source (output valid, gesture_event, input ready);
  modport sink   (input valid, gesture_event, output ready);
endinterface
`default_nettype wire

### hdl/bgd_lane.sv
`default_nettype none
module bgd_lane (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bgd_pkg::lane_const_t lane_const,
  input  wire logic                 level,
  input  wire logic                 suppress,
  input  wire bgd_pkg::stamp_t      now_ms,
  input  wire bgd_pkg::cfg_word_t   long_press_ms,
  input  wire bgd_pkg::cfg_word_t   double_gap_ms,
  input  wire logic                 step_en,
  output bgd_pkg::event_t           lane_ev
);

  localparam logic [bgd_pkg::PhaseW-1:0] PhIdle   = 3'd0;
  localparam logic [bgd_pkg::PhaseW-1:0] PhDown   = 3'd1;
  localparam logic [bgd_pkg::PhaseW-1:0] PhUpWait = 3'd2;
  localparam logic [bgd_pkg::PhaseW-1:0] PhLong   = 3'd3;
  localparam logic [bgd_pkg::PhaseW-1:0] PhCombo  = 3'd4;

  logic [bgd_pkg::PhaseW-1:0] phase_r, phase_nxt;
  bgd_pkg::stamp_t            press_r, press_nxt;
  bgd_pkg::stamp_t            release_r, release_nxt;
  bgd_pkg::stamp_t            held, gap;
  logic                       long_hit, gap_ok;

  // wrapping differences
  assign held     = now_ms - press_r;
  assign gap      = now_ms - release_r;
  assign long_hit = held >= bgd_pkg::stamp_t'(long_press_ms);
  assign gap_ok   = gap <= bgd_pkg::stamp_t'(double_gap_ms);

  always_comb begin
    phase_nxt   = phase_r;
    press_nxt   = press_r;
    release_nxt = release_r;
    lane_ev     = bgd_pkg::EvNone;
    unique case (phase_r)
      PhDown: begin
        if (suppress) begin
          phase_nxt = PhCombo;
        end else if (!level) begin
          release_nxt = now_ms;
          if (lane_const.has_double) begin
            phase_nxt = PhUpWait;
          end else begin
            phase_nxt = PhIdle;
            lane_ev   = lane_const.ev_short;
          end
        end else if (long_hit) begin
          phase_nxt = PhLong;
          lane_ev   = lane_const.ev_long;
        end
      end
      PhUpWait: begin
        if (level) begin
          if (gap_ok) begin
            phase_nxt = PhLong;
            lane_ev   = lane_const.ev_double;
          end else begin
            phase_nxt = PhDown;
            press_nxt = now_ms;
          end
        end else if (!gap_ok) begin
          phase_nxt = PhIdle;
          lane_ev   = lane_const.ev_short;
        end
      end
      PhLong: begin
        if (!level) phase_nxt = PhIdle;
      end
      PhCombo: begin
        if (!level && !suppress) phase_nxt = PhIdle;
      end
      default: begin
        // idle and unused codes
        phase_nxt = PhIdle;
        if (level) begin
          phase_nxt = PhDown;
          press_nxt = now_ms;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PhIdle;
      press_r   <= '0;
      release_r <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      press_r   <= press_nxt;
      release_r <= release_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_when_skipped: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(phase_r) && $stable(press_r) && $stable(release_r))
    else $error("lane state moved without a step");

  a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ev != bgd_pkg::EvNone |-> phase_r == PhDown || phase_r == PhUpWait)
    else $error("event from a phase that cannot fire");

  a_combo_entry: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && phase_r == PhDown && suppress |=> phase_r == PhCombo)
    else $error("suppressed press did not enter combo");
`endif

endmodule
`default_nettype wire

### hdl/bgd_merge.sv
`default_nettype none
module bgd_merge (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_take,
  input  wire bgd_pkg::event_t [bgd_pkg::LaneN-1:0]   lane_ev,
  output logic [bgd_pkg::LaneN-1:0]                   lane_en,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output bgd_pkg::event_t                             gesture_event
);

  logic            accept;
  logic            valid_r;
  bgd_pkg::event_t event_r, event_nxt;

  assign in_take = !valid_r || out_ready;
  assign accept  = in_valid && in_take;

  // first lane with an event wins, later lanes hold
  always_comb begin
    lane_en   = '0;
    event_nxt = bgd_pkg::EvNone;
    for (int k = 0; k < bgd_pkg::LaneN; k++) begin
      if (event_nxt == bgd_pkg::EvNone) begin
        lane_en[k] = accept;
        event_nxt  = lane_ev[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) event_r <= event_nxt;
  end

  assign out_valid     = valid_r;
  assign gesture_event = event_r;

`ifndef NO_ASSERTIONS
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> valid_r)
    else $error("accepted transaction produced no result");

  a_left_wins: assert property (@(posedge clk) disable iff (!rst_n)
    accept && lane_ev[0] != bgd_pkg::EvNone |=> event_r == $past(lane_ev[0]))
    else $error("left event lost");

  a_later_gated: assert property (@(posedge clk) disable iff (!rst_n)
    lane_en[2] |-> lane_ev[0] == bgd_pkg::EvNone && lane_ev[1] == bgd_pkg::EvNone)
    else $error("right lane stepped after an earlier event");
`endif

endmodule
`default_nettype wire

### hdl/button_gesture_detector_top.sv
`default_nettype none
// channel   dir  handshake        payload
// in_ch     in   valid/ready      left_low, mid_low, right_low, now_ms[31:0]
// out_ch    out  valid/ready      gesture_event[3:0]
// cfg_*     in   cfg_we only      cfg_idx (0 long press, 1 double gap), cfg_wdata[15:0]
//
// one poll per clock while in_ch.ready is high; the result appears in the cycle after acceptance
// the result is held in the single output register behind the lane merge
// in_ch.ready is low only while a result waits and out_ch.ready is low
// synchronous active-low reset: buttons idle, timestamps zero, 2000/350 ms
module button_gesture_detector_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  bgd_in_if.sink                  in_ch,
  bgd_out_if.source               out_ch,
  input  wire logic               cfg_we,
  input  wire logic               cfg_idx,
  input  wire bgd_pkg::cfg_word_t cfg_wdata
);

  bgd_pkg::cfg_word_t                       long_press_r;
  bgd_pkg::cfg_word_t                       double_gap_r;
  bgd_pkg::event_t [bgd_pkg::LaneN-1:0]     lane_ev;
  logic [bgd_pkg::LaneN-1:0]                lane_en;
  logic                                     in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= bgd_pkg::LongPressRst;
      double_gap_r <= bgd_pkg::DoubleGapRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bgd_pkg::CfgIdxLongPress: long_press_r <= cfg_wdata;
        bgd_pkg::CfgIdxDoubleGap: double_gap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_take;

  // left is suppressed by right and right by left
  bgd_lane u_lane_left (
    .clk           (clk),
    .rst_n         (rst_n),
    .lane_const    (bgd_pkg::LaneLeft),
    .level         (in_ch.left_low),
    .suppress      (in_ch.right_low),
    .now_ms        (in_ch.now_ms),
    .long_press_ms (long_press_r),
    .double_gap_ms (double_gap_r),
    .step_en       (lane_en[0]),
    .lane_ev       (lane_ev[0])
  );

  bgd_lane u_lane_mid (
    .clk           (clk),
    .rst_n         (rst_n),
    .lane_const    (bgd_pkg::LaneMid),
    .level         (in_ch.mid_low),
    .suppress      (1'b0),
    .now_ms        (in_ch.now_ms),
    .long_press_ms (long_press_r),
    .double_gap_ms (double_gap_r),
    .step_en       (lane_en[1]),
    .lane_ev       (lane_ev[1])
  );

  bgd_lane u_lane_right (
    .clk           (clk),
    .rst_n         (rst_n),
    .lane_const    (bgd_pkg::LaneRight),
    .level         (in_ch.right_low),
    .suppress      (in_ch.left_low),
    .now_ms        (in_ch.now_ms),
    .long_press_ms (long_press_r),
    .double_gap_ms (double_gap_r),
    .step_en       (lane_en[2]),
    .lane_ev       (lane_ev[2])
  );

  bgd_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_take       (in_take),
    .lane_ev       (lane_ev),
    .lane_en       (lane_en),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .gesture_event (out_ch.gesture_event)
  );

endmodule
`default_nettype wire

### tb/gesture_event_checker.sv
module gesture_event_checker
  import bgd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  bgd_in_if              in_ch,
  bgd_out_if             out_ch,
  input  wire logic      cfg_we,
  input  wire logic      cfg_idx,
  input  wire cfg_word_t cfg_wdata,
  output int             fail_count,
  output int             results_owed
);

  typedef enum logic [PhaseW-1:0] {
    PhIdle, PhDown, PhUpWait, PhLong, PhCombo
  } phase_t;

  localparam lane_const_t LaneTab [LaneN] = '{LaneLeft, LaneMid, LaneRight};

  phase_t    phase       [LaneN];
  stamp_t    pressed_at  [LaneN];
  stamp_t    released_at [LaneN];
  cfg_word_t long_ms;
  cfg_word_t gap_ms;
  event_t    gesture_queue [$];
  int        mismatches = 0;

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  // advances one button for one poll, returns its event
  function automatic event_t step_button(int k, logic pressed, logic blocked, stamp_t t);
    stamp_t held;
    stamp_t idle_gap;
    held     = t - pressed_at[k];
    idle_gap = t - released_at[k];
    case (phase[k])
      PhDown: begin
        if (blocked) begin
          phase[k] = PhCombo;
          return EvNone;
        end
        if (!pressed) begin
          released_at[k] = t;
          if (!LaneTab[k].has_double) begin
            phase[k] = PhIdle;
            return LaneTab[k].ev_short;
          end
          phase[k] = PhUpWait;
          return EvNone;
        end
        if (held >= stamp_t'(long_ms)) begin
          phase[k] = PhLong;
          return LaneTab[k].ev_long;
        end
        return EvNone;
      end
      PhUpWait: begin
        if (pressed) begin
          if (idle_gap <= stamp_t'(gap_ms)) begin
            phase[k] = PhLong;
            return LaneTab[k].ev_double;
          end
          phase[k]      = PhDown;
          pressed_at[k] = t;
          return EvNone;
        end
        if (idle_gap > stamp_t'(gap_ms)) begin
          phase[k] = PhIdle;
          return LaneTab[k].ev_short;
        end
        return EvNone;
      end
      PhLong: begin
        if (!pressed) phase[k] = PhIdle;
        return EvNone;
      end
      PhCombo: begin
        if (!pressed && !blocked) phase[k] = PhIdle;
        return EvNone;
      end
      default: begin
        phase[k] = pressed ? PhDown : PhIdle;
        if (pressed) pressed_at[k] = t;
        return EvNone;
      end
    endcase
  endfunction

  always @(posedge clk) begin : track
    event_t got;
    event_t want;
    event_t ev;
    if (!rst_n) begin
      for (int k = 0; k < LaneN; k++) begin
        phase[k]       = PhIdle;
        pressed_at[k]  = '0;
        released_at[k] = '0;
      end
      long_ms = LongPressRst;
      gap_ms  = DoubleGapRst;
      gesture_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CfgIdxLongPress) long_ms = cfg_wdata;
        else gap_ms = cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.gesture_event;
        if (gesture_queue.size() == 0) begin
          mismatches++;
          $display("%0t gesture_event mismatch: expected none, actual %0d", $time, got);
        end else begin
          want = gesture_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t gesture_event mismatch: expected %0d, actual %0d",
                     $time, want, got);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        // left, then mid, then right; first event ends the poll
        ev = step_button(0, in_ch.left_low, in_ch.right_low, in_ch.now_ms);
        if (ev == EvNone) ev = step_button(1, in_ch.mid_low, 1'b0, in_ch.now_ms);
        if (ev == EvNone) ev = step_button(2, in_ch.right_low, in_ch.left_low, in_ch.now_ms);
        gesture_queue.push_back(ev);
      end
    end
    fail_count   <= mismatches;
    results_owed <= gesture_queue.size();
  end

endmodule

### tb/tb_button_gesture_detector_top.sv
module tb_button_gesture_detector_top;
  import bgd_pkg::*;

  localparam int QuietLimit   = 1000;
  localparam int PhasePolls   = 170;
  localparam int SettingN     = 8;
  localparam int RandomPhase  = 6;
  localparam int unsigned LongSet [SettingN] = '{1, 65535, 0, 65535, 1, 300, 0, 2000};
  localparam int unsigned GapSet  [SettingN] = '{1, 65535, 0, 1, 65535, 80, 0, 350};

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic      cfg_idx;
  cfg_word_t cfg_wdata;

  bgd_in_if  in_ch ();
  bgd_out_if out_ch ();

  int          fail_count;
  int          results_owed;
  bit          calm = 1'b0;
  logic [2:0]  levels = 3'b000;    // bit 0 left, bit 1 mid, bit 2 right
  stamp_t      now_ms = 32'hFFFF_FC00;
  int unsigned long_mark = 2000;
  int unsigned gap_mark = 350;
  int          polls_sent = 0;
  int          quiet_cycles;

  button_gesture_detector_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  gesture_event_checker u_event_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // one poll transaction with the current levels, timestamp moved on first
  task automatic send_poll(input int unsigned advance_ms);
    now_ms = now_ms + advance_ms;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.left_low  <= levels[0];
    in_ch.mid_low   <= levels[1];
    in_ch.right_low <= levels[2];
    in_ch.now_ms    <= now_ms;
    do @(posedge clk); while (!in_ch.ready);
    polls_sent++;
  endtask

  task automatic poll_with(input logic [2:0] lv, input int unsigned advance_ms);
    levels = lv;
    send_poll(advance_ms);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input cfg_word_t value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int unsigned lp, input int unsigned dg);
    settle();
    write_reg(CfgIdxLongPress, cfg_word_t'(lp));
    write_reg(CfgIdxDoubleGap, cfg_word_t'(dg));
    long_mark = lp;
    gap_mark  = dg;
  endtask

  // a delay on or next to a threshold, or anywhere up to twice it plus one
  function automatic int unsigned around(int unsigned mark);
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return (mark == 0) ? 0 : mark - 1;
      2:       return mark;
      3:       return mark + 1;
      default: return $urandom_range(2 * mark + 1, 0);
    endcase
  endfunction

  task automatic short_press(input int k);
    int holds;
    holds = (long_mark > 1) ? $urandom_range(0, 2) : 0;
    levels[k] = 1'b1;
    send_poll(gap_mark + 1 + $urandom_range(0, 30));
    repeat (holds) send_poll($urandom_range(0, (long_mark - 1) / 3));
    levels[k] = 1'b0;
    send_poll(around(long_mark));
    repeat ($urandom_range(0, 2)) send_poll($urandom_range(0, gap_mark / 3));
    send_poll(gap_mark + 1 + $urandom_range(0, 2));
  endtask

  task automatic double_press(input int k);
    int unsigned second;
    levels[k] = 1'b1;
    send_poll(gap_mark + 1 + $urandom_range(0, 30));
    levels[k] = 1'b0;
    send_poll($urandom_range(0, long_mark + 4));
    case ($urandom_range(0, 3))
      0:       second = 0;
      1:       second = gap_mark;
      2:       second = gap_mark + 1;
      default: second = $urandom_range(0, gap_mark);
    endcase
    levels[k] = 1'b1;
    send_poll(second);
    repeat ($urandom_range(0, 2)) send_poll($urandom_range(0, long_mark + 4));
    levels[k] = 1'b0;
    send_poll($urandom_range(0, 40));
    // a late second press still has to time out
    send_poll(gap_mark + 1);
  endtask

  task automatic long_press(input int k);
    int unsigned held;
    int unsigned stride;
    levels[k] = 1'b1;
    send_poll(gap_mark + 1 + $urandom_range(0, 30));
    held = 0;
    while (held < long_mark) begin
      case ($urandom_range(0, 3))
        0:       stride = long_mark - held;
        1:       stride = (long_mark - held > 1) ? long_mark - held - 1 : 1;
        default: stride = $urandom_range(0, long_mark - held);
      endcase
      held += stride;
      send_poll(stride);
    end
    repeat ($urandom_range(1, 3)) send_poll($urandom_range(0, 20));
    levels[k] = 1'b0;
    send_poll($urandom_range(0, 20));
  endtask

  // left and right held together
  task automatic combo();
    levels[0] = 1'b1;
    if ($urandom_range(0, 1) != 0) send_poll(around(gap_mark));
    levels[2] = 1'b1;
    if ($urandom_range(0, 3) == 0) levels[1] = ~levels[1];
    send_poll($urandom_range(0, 30));
    repeat ($urandom_range(0, 2)) send_poll(around(long_mark));
    if ($urandom_range(0, 1) != 0) levels[0] = 1'b0;
    else levels[2] = 1'b0;
    send_poll(around(gap_mark));
    levels = 3'b000;
    send_poll(around(gap_mark));
    send_poll(gap_mark + 1);
  endtask

  // two buttons timing out on the same poll
  task automatic race();
    int a;
    int b;
    a = $urandom_range(0, 1);
    b = a + 1 + $urandom_range(0, 1 - a);
    levels[a] = 1'b1;
    levels[b] = 1'b1;
    send_poll(gap_mark + 1 + $urandom_range(0, 30));
    levels[a] = 1'b0;
    levels[b] = 1'b0;
    send_poll($urandom_range(0, 30));
    send_poll(gap_mark + 1);
    send_poll($urandom_range(0, 3));
  endtask

  task automatic noise();
    repeat ($urandom_range(1, 8)) begin
      levels = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0, 1:    send_poll($urandom_range(0, 5));
        2:       send_poll(around(gap_mark));
        3:       send_poll(around(long_mark));
        4:       send_poll($urandom());
        default: send_poll($urandom_range(0, 500));
      endcase
    end
  endtask

  task automatic run_gestures(input int polls);
    int stop;
    stop = polls_sent + polls;
    while (polls_sent < stop) begin
      if ($urandom_range(0, 15) == 0) now_ms = stamp_t'($urandom());
      case ($urandom_range(0, 9))
        0, 1:    short_press($urandom_range(0, 2));
        2, 3:    double_press($urandom_range(0, 2));
        4, 5:    long_press($urandom_range(0, 2));
        6:       combo();
        7:       race();
        default: noise();
      endcase
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.left_low  <= 1'b0;
    in_ch.mid_low   <= 1'b0;
    in_ch.right_low <= 1'b0;
    in_ch.now_ms    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on reset settings, timestamps wrap early on
    poll_with(3'b000, 0);
    poll_with(3'b001, 10);
    poll_with(3'b000, 100);
    poll_with(3'b001, 350);      // second press right at the double gap
    poll_with(3'b000, 50);
    poll_with(3'b001, 5);
    poll_with(3'b000, 1999);
    poll_with(3'b000, 351);      // just past the gap: left short
    poll_with(3'b010, 3);
    poll_with(3'b010, 1999);
    poll_with(3'b010, 1);        // held exactly the long time
    poll_with(3'b000, 7);
    poll_with(3'b100, 4);
    poll_with(3'b000, 9000);     // right fires short on release
    poll_with(3'b100, 1);
    poll_with(3'b100, 2000);
    poll_with(3'b000, 1);
    poll_with(3'b101, 2);        // left and right together get suppressed
    poll_with(3'b101, 3000);
    poll_with(3'b100, 5);
    poll_with(3'b000, 5);
    poll_with(3'b011, 3);        // left and mid together: left wins the timeout, mid fires next
    poll_with(3'b000, 20);
    poll_with(3'b000, 400);
    poll_with(3'b000, 1);

    run_gestures(200);
    for (int i = 0; i < SettingN; i++) begin
      if (i == RandomPhase)
        apply_setting($urandom_range(1, 65535), $urandom_range(1, 65535));
      else
        apply_setting(LongSet[i], GapSet[i]);
      if (i == SettingN - 1) calm = 1'b1;
      run_gestures(PhasePolls);
    end

    settle();
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
